// ===== design/sgp_pkg.sv =====
package sgp_pkg;

    localparam int TABLE_ENTRIES_DEF = 9;
    localparam int FIRST_POINT_Q4    = 320;
    localparam int DEGREE_STEP_Q4    = 160;
    localparam int NEAR_COUNTS       = 6;

    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 12;
    localparam int TEMP_W   = 12;
    localparam int TCLAMP_W = 11;
    localparam int DELAY_W  = 16;
    localparam int IDX_W    = 4;
    localparam int NUM_W    = 24;
    localparam int TAB_LO_W = 60;
    localparam int TAB_HI_W = 48;
    localparam int CFG_W    = 60;
    localparam int CFG_IDX_W = 3;

    // Interpolation numerator that maps to the top of the angle range.
    localparam int NUM_SAT  = 4096 * DEGREE_STEP_Q4;
    // Reciprocal of five in Q18, exact for dividends below 2^18.
    localparam int RECIP5_Q18 = 52429;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOME_ANGLE    = 3'd0,
        CFG_TEMP_FLOOR    = 3'd1,
        CFG_TEMP_CEILING  = 3'd2,
        CFG_STEP_INTERVAL = 3'd3,
        CFG_TABLE_LOW     = 3'd4,
        CFG_TABLE_HIGH    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [ANGLE_W-1:0]  sensed;
        logic [TCLAMP_W-1:0] temp_c;
        logic [ANGLE_W-1:0]  target;
        logic [DELAY_W-1:0]  delay;
    } t_track;

    // Q16 spacing factors 1 - (d/6)^0.33 for d below six counts.
    function automatic logic [16:0] near_factor(input logic [2:0] d);
        logic [16:0] f;
        unique case (d)
            3'd0:    f = 17'd65536;
            3'd1:    f = 17'd29254;
            3'd2:    f = 17'd19929;
            3'd3:    f = 17'd13400;
            3'd4:    f = 17'd8208;
            3'd5:    f = 17'd3827;
            default: f = 17'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== design/sgp_interp.sv =====
module sgp_interp #(
    parameter int TABLE_ENTRIES = sgp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic [sgp_pkg::TEMP_W-1:0]   i_temp,
    input  logic [sgp_pkg::TCLAMP_W-1:0] i_floor,
    input  logic [sgp_pkg::TCLAMP_W-1:0] i_ceiling,
    input  logic [sgp_pkg::TAB_LO_W-1:0] i_tab_lo,
    input  logic [sgp_pkg::TAB_HI_W-1:0] i_tab_hi,
    output logic [sgp_pkg::TCLAMP_W-1:0] o_temp_c,
    output logic signed [sgp_pkg::NUM_W-1:0] o_num
);
    import sgp_pkg::*;

    localparam logic [IDX_W-1:0] LO_MAX = IDX_W'(TABLE_ENTRIES - 2);

    function automatic logic [ANGLE_W-1:0] table_angle(
        input logic [TAB_LO_W-1:0] tab_lo,
        input logic [TAB_HI_W-1:0] tab_hi,
        input logic [IDX_W-1:0]    idx
    );
        logic [ANGLE_W-1:0] a;
        unique case (idx)
            4'd0:    a = tab_lo[11:0];
            4'd1:    a = tab_lo[23:12];
            4'd2:    a = tab_lo[35:24];
            4'd3:    a = tab_lo[47:36];
            4'd4:    a = tab_lo[59:48];
            4'd5:    a = tab_hi[11:0];
            4'd6:    a = tab_hi[23:12];
            4'd7:    a = tab_hi[35:24];
            4'd8:    a = tab_hi[47:36];
            default: a = '0;
        endcase
        return a;
    endfunction

    logic [TCLAMP_W-1:0] tc;
    logic [9:0]          q_prod;
    logic [IDX_W-1:0]    q;
    logic [IDX_W-1:0]    lo;
    logic [ANGLE_W-1:0]  a0;
    logic [ANGLE_W-1:0]  a1;
    logic [11:0]         base;
    logic signed [12:0]  diff;
    logic signed [12:0]  slope;
    logic signed [25:0]  prod;
    logic [19:0]         a0_scaled;

    always_comb begin
        if ({1'b0, i_floor} > i_temp) begin
            tc = i_floor;
        end else if (i_temp > {1'b0, i_ceiling}) begin
            tc = i_ceiling;
        end else begin
            tc = i_temp[TCLAMP_W-1:0];
        end

        // Divide by 160 as a shift by 5 and a multiply by 13/64.
        q_prod = 10'(tc[10:5]) * 10'd13;
        q      = q_prod[9:6];
        lo     = (q < 4'd2) ? 4'd0 : q - 4'd2;
        if (lo > LO_MAX) begin
            lo = LO_MAX;
        end

        a0 = table_angle(i_tab_lo, i_tab_hi, lo);
        a1 = table_angle(i_tab_lo, i_tab_hi, lo + 4'd1);

        base      = 12'(FIRST_POINT_Q4) + 12'(lo) * 12'(DEGREE_STEP_Q4);
        diff      = $signed({2'b00, tc}) - $signed({1'b0, base});
        slope     = $signed({1'b0, a1}) - $signed({1'b0, a0});
        prod      = diff * slope;
        a0_scaled = 20'(a0) * 20'(DEGREE_STEP_Q4);
    end

    assign o_temp_c = tc;
    assign o_num    = $signed(prod[NUM_W-1:0]) + $signed({4'b0000, a0_scaled});

endmodule

// ===== design/sgp_scale.sv =====
module sgp_scale (
    input  logic signed [sgp_pkg::NUM_W-1:0] i_num,
    output logic [sgp_pkg::ANGLE_W-1:0]      o_target
);
    import sgp_pkg::*;

    logic [14:0] q;
    logic [30:0] p;

    assign q = i_num[19:5];
    assign p = 31'(q) * 31'(RECIP5_Q18);

    always_comb begin
        priority if (i_num[NUM_W-1]) begin
            o_target = '0;
        end else if (i_num[NUM_W-2:0] >= (NUM_W-1)'(NUM_SAT)) begin
            o_target = '1;
        end else begin
            o_target = p[29:18];
        end
    end

endmodule

// ===== design/sgp_spacing.sv =====
module sgp_spacing (
    input  logic [sgp_pkg::ANGLE_W-1:0] i_sensed,
    input  logic [sgp_pkg::ANGLE_W-1:0] i_target,
    input  logic [sgp_pkg::DELAY_W-1:0] i_interval,
    output logic [sgp_pkg::DELAY_W-1:0] o_delay
);
    import sgp_pkg::*;

    logic [ANGLE_W-1:0] d;
    logic [32:0]        p;

    assign d = (i_sensed > i_target) ? i_sensed - i_target : i_target - i_sensed;
    assign p = 33'(i_interval) * 33'(near_factor(d[2:0]));

    always_comb begin
        if (d >= ANGLE_W'(NEAR_COUNTS)) begin
            o_delay = '0;
        end else begin
            o_delay = p[31:16];
        end
    end

endmodule

// ===== design/sgp_track.sv =====
module sgp_track (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  sgp_pkg::t_track              i_item,
    input  logic [sgp_pkg::ANGLE_W-1:0]  i_home_angle,
    output logic [1:0]                   o_dir,
    output logic                         o_homed,
    output logic [sgp_pkg::ANGLE_W-1:0]  o_target,
    output logic [sgp_pkg::DELAY_W-1:0]  o_delay
);
    import sgp_pkg::*;

    logic               r_homed_flag;
    logic [TEMP_W-1:0]  r_settled;
    logic [TIME_W-1:0]  r_last_step;
    logic               n_homed_flag;
    logic [TEMP_W-1:0]  n_settled;
    logic [TIME_W-1:0]  n_last_step;

    t_dir               r_dir;
    logic [ANGLE_W-1:0] r_target;
    logic [DELAY_W-1:0] r_delay;
    t_dir               n_dir;
    logic [ANGLE_W-1:0] n_target;
    logic [DELAY_W-1:0] n_delay;

    logic [TIME_W-1:0]  elapsed;
    logic               may_step;

    assign elapsed  = i_item.now_ms - r_last_step;
    assign may_step = (elapsed >= TIME_W'(i_item.delay)) &&
                      ({1'b0, i_item.temp_c} != r_settled);

    always_comb begin
        n_homed_flag = r_homed_flag;
        n_settled    = r_settled;
        n_last_step  = r_last_step;
        n_dir        = DIR_HOLD;
        n_target     = '0;
        n_delay      = '0;
        if (!r_homed_flag) begin
            priority if (i_item.sensed < i_home_angle) begin
                n_dir = DIR_FWD;
            end else if (i_item.sensed > i_home_angle) begin
                n_dir = DIR_BACK;
            end else begin
                n_homed_flag = 1'b1;
            end
        end else begin
            n_target = i_item.target;
            n_delay  = i_item.delay;
            if (may_step) begin
                priority if (i_item.sensed < i_item.target) begin
                    n_dir       = DIR_FWD;
                    n_last_step = i_item.now_ms;
                end else if (i_item.sensed > i_item.target) begin
                    n_dir       = DIR_BACK;
                    n_last_step = i_item.now_ms;
                end else begin
                    n_settled = {1'b0, i_item.temp_c};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_homed_flag <= 1'b0;
            r_settled    <= '0;
            r_last_step  <= '0;
        end else if (i_load) begin
            r_homed_flag <= n_homed_flag;
            r_settled    <= n_settled;
            r_last_step  <= n_last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dir    <= n_dir;
            r_target <= n_target;
            r_delay  <= n_delay;
        end
    end

    assign o_dir    = r_dir;
    assign o_homed  = r_homed_flag;
    assign o_target = r_target;
    assign o_delay  = r_delay;

endmodule

// ===== design/stepper_gauge_positioner_unit.sv =====
// Stepper gauge needle positioner.
// The input stream carries one control tick per item: the millisecond time, the
// sensed needle angle and the requested temperature. The output stream returns
// one item per input item: the step direction, the homed flag, the target angle
// and the step spacing in milliseconds. Registers are written through a plain
// write port (enable, index, data); the user must write them only while no item
// is in flight, which the block does not enforce. The block is a pipeline of
// five register stages: input register, clamp and interpolation product,
// scaling to the target angle, step spacing, and the decision stage that holds
// the homing and tracking state and the result. One item is accepted per cycle
// while the receiver does not stall; the only loop is the homed, settled and last
// step state in the decision stage, which is updated in the cycle that loads
// the result register.
// Reset empties the pipeline, clears the homed flag, the settled temperature
// and the last step time, and loads the register defaults.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; s_axis_tready falls once all five stages hold items.
module stepper_gauge_positioner_unit #(
    parameter int TABLE_ENTRIES = sgp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_ms[31:0], sensed_angle[43:32], temperature[55:44]
    input  logic [55:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // step_dir[1:0], homed[2], target_angle[14:3], step_delay_ms[30:15], zero[31]
    output logic [31:0]                    m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [sgp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgp_pkg::CFG_W-1:0]      i_cfg_data
);
    import sgp_pkg::*;

    logic [ANGLE_W-1:0]  r_home_angle;
    logic [TCLAMP_W-1:0] r_temp_floor;
    logic [TCLAMP_W-1:0] r_temp_ceiling;
    logic [DELAY_W-1:0]  r_interval;
    logic [TAB_LO_W-1:0] r_tab_lo;
    logic [TAB_HI_W-1:0] r_tab_hi;

    logic r_v0;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;
    logic en0;
    logic en1;
    logic en2;
    logic en3;
    logic eno;

    logic [TIME_W-1:0]   r_s0_now;
    logic [ANGLE_W-1:0]  r_s0_sensed;
    logic [TEMP_W-1:0]   r_s0_temp;

    logic [TIME_W-1:0]   r_s1_now;
    logic [ANGLE_W-1:0]  r_s1_sensed;
    logic [TCLAMP_W-1:0] r_s1_tc;
    logic signed [NUM_W-1:0] r_s1_num;

    logic [TIME_W-1:0]   r_s2_now;
    logic [ANGLE_W-1:0]  r_s2_sensed;
    logic [TCLAMP_W-1:0] r_s2_tc;
    logic [ANGLE_W-1:0]  r_s2_target;

    t_track              r_s3;

    logic [TCLAMP_W-1:0] n_tc;
    logic signed [NUM_W-1:0] n_num;
    logic [ANGLE_W-1:0]  n_target;
    logic [DELAY_W-1:0]  n_delay;

    logic [1:0]          out_dir;
    logic                out_homed;
    logic [ANGLE_W-1:0]  out_target;
    logic [DELAY_W-1:0]  out_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_angle   <= '0;
            r_temp_floor   <= TCLAMP_W'(320);
            r_temp_ceiling <= TCLAMP_W'(1600);
            r_interval     <= DELAY_W'(100);
            r_tab_lo       <= '0;
            r_tab_hi       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HOME_ANGLE:    r_home_angle   <= i_cfg_data[ANGLE_W-1:0];
                CFG_TEMP_FLOOR:    r_temp_floor   <= i_cfg_data[TCLAMP_W-1:0];
                CFG_TEMP_CEILING:  r_temp_ceiling <= i_cfg_data[TCLAMP_W-1:0];
                CFG_STEP_INTERVAL: r_interval     <= i_cfg_data[DELAY_W-1:0];
                CFG_TABLE_LOW:     r_tab_lo       <= i_cfg_data[TAB_LO_W-1:0];
                CFG_TABLE_HIGH:    r_tab_hi       <= i_cfg_data[TAB_HI_W-1:0];
                default: ;
            endcase
        end
    end

    assign eno = !r_vo || m_axis_tready;
    assign en3 = !r_v3 || eno;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign s_axis_tready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en0) r_v0 <= s_axis_tvalid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (eno) r_vo <= r_v3;
        end
    end

    sgp_interp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_interp (
        .i_temp    (r_s0_temp),
        .i_floor   (r_temp_floor),
        .i_ceiling (r_temp_ceiling),
        .i_tab_lo  (r_tab_lo),
        .i_tab_hi  (r_tab_hi),
        .o_temp_c  (n_tc),
        .o_num     (n_num)
    );

    sgp_scale u_scale (
        .i_num    (r_s1_num),
        .o_target (n_target)
    );

    sgp_spacing u_spacing (
        .i_sensed   (r_s2_sensed),
        .i_target   (r_s2_target),
        .i_interval (r_interval),
        .o_delay    (n_delay)
    );

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_s0_now    <= s_axis_tdata[31:0];
            r_s0_sensed <= s_axis_tdata[43:32];
            r_s0_temp   <= s_axis_tdata[55:44];
        end
        if (en1) begin
            r_s1_now    <= r_s0_now;
            r_s1_sensed <= r_s0_sensed;
            r_s1_tc     <= n_tc;
            r_s1_num    <= n_num;
        end
        if (en2) begin
            r_s2_now    <= r_s1_now;
            r_s2_sensed <= r_s1_sensed;
            r_s2_tc     <= r_s1_tc;
            r_s2_target <= n_target;
        end
        if (en3) begin
            r_s3.now_ms <= r_s2_now;
            r_s3.sensed <= r_s2_sensed;
            r_s3.temp_c <= r_s2_tc;
            r_s3.target <= r_s2_target;
            r_s3.delay  <= n_delay;
        end
    end

    sgp_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (eno && r_v3),
        .i_item       (r_s3),
        .i_home_angle (r_home_angle),
        .o_dir        (out_dir),
        .o_homed      (out_homed),
        .o_target     (out_target),
        .o_delay      (out_delay)
    );

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {1'b0, out_delay, out_target, out_homed, out_dir};

endmodule

// ===== design/sgp_checker.sv =====
module sgp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import sgp_pkg::*;

    logic r_seen_homed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_homed <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tdata[2]) begin
            r_seen_homed <= 1'b1;
        end
    end

    a_homed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_homed |-> m_axis_tdata[2])
        else $error("homed flag fell after homing finished");

    a_homing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[30:3] == 28'd0)
        else $error("target or spacing nonzero while homing");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == DIR_HOLD || m_axis_tdata[1:0] == DIR_FWD ||
                           m_axis_tdata[1:0] == DIR_BACK))
        else $error("step direction code out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind stepper_gauge_positioner_unit sgp_checker u_sgp_checker (.*);
